@@ rtl/core/rdc_pkg.sv @@
// shared widths, register indexes and types of the row delta codec
package rdc_pkg;

    localparam int MAX_STRIDE = 4096;
    localparam int COL_W      = $clog2(MAX_STRIDE);
    localparam int PIXEL_W    = 8;
    localparam int STRIDE_W   = 13;
    localparam int ROWS_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 2'd2;

    typedef enum logic
    {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } dir_t;

    // item held between line store read and result register
    typedef struct packed
    {
        logic [PIXEL_W-1:0] pixel;
        logic [COL_W-1:0]   col;
        logic               first;
        logic               frame_end;
        dir_t               dir;
        logic               bypass;
    } stage_t;

endpackage

@@ rtl/core/rdc_if.sv @@
// item channels of the row delta codec

interface rdc_in_if;
    logic                        valid;
    logic                        ready;
    logic [rdc_pkg::PIXEL_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);
endinterface

interface rdc_out_if;
    logic                        valid;
    logic                        ready;
    logic [rdc_pkg::PIXEL_W-1:0] pixel_out;
    logic                        first_row;
    logic                        frame_end;

    modport source (output valid, output pixel_out, output first_row, output frame_end,
                    input ready);
    modport sink (input valid, input pixel_out, input first_row, input frame_end,
                  output ready);
endinterface

@@ rtl/core/rdc_ram.sv @@
// generic single write port ram with registered read
module rdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/row_delta_codec.sv @@
// top level of the row delta codec (vertical up filter over a raster byte stream)
//
// usage
//   in_item carries one byte per item in raster order: raw bytes when encoding,
//   delta bytes when decoding. out_item returns exactly one item per input item
//   with the filtered byte, a first row flag and a frame end flag
//   configuration is written through cfg_we / cfg_idx / cfg_wdata while idle:
//   line stride, row count and direction
// throughput and pipeline
//   one item per clock cycle sustained while out_item is not stalled; the line store
//   read registers with the item in the read stage, and from there the filter
//   feeds the result register, which drives out_item
// reset
//   counters return to the start of a frame, config to stride 1, one row, encode;
//   the line store is not cleared, every entry that later rows read is written by the first row
// stalls
//   the result register and the line store read stage each hold one item, so
//   input keeps flowing while a result waits; when out_item is stalled with both
//   stages full, in_item ready drops until the result is taken
module row_delta_codec (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rdc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [rdc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    rdc_in_if.sink                         in_item,
    rdc_out_if.source                      out_item
);

    // configuration registers
    logic [rdc_pkg::STRIDE_W-1:0] stride_reg;
    logic [rdc_pkg::ROWS_W-1:0]   rows_reg;
    rdc_pkg::dir_t                dir_reg;

    // frame position
    logic [rdc_pkg::COL_W-1:0]  col_reg, col_next;
    logic [rdc_pkg::ROWS_W-1:0] row_reg, row_next;

    // line store read stage
    logic                        s1_valid_reg, s1_valid_next;
    rdc_pkg::stage_t             s1_reg;
    logic [rdc_pkg::PIXEL_W-1:0] byp_data_reg;

    // result register
    logic                        out_valid_reg, out_valid_next;
    logic [rdc_pkg::PIXEL_W-1:0] out_pixel_reg;
    logic                        out_first_reg;
    logic                        out_end_reg;

    logic [rdc_pkg::STRIDE_W-1:0] stride_eff;
    logic [rdc_pkg::ROWS_W-1:0]   rows_eff;
    logic [rdc_pkg::STRIDE_W-1:0] col_plus;
    logic [rdc_pkg::ROWS_W:0]     row_plus;
    logic                         row_end;
    logic                         last_row;
    logic                         in_fire;
    logic                         s1_adv;
    logic [rdc_pkg::PIXEL_W-1:0]  ram_rdata;
    logic [rdc_pkg::PIXEL_W-1:0]  above;
    logic [rdc_pkg::PIXEL_W-1:0]  result;
    logic [rdc_pkg::PIXEL_W-1:0]  raw;

    // config writes, indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= rdc_pkg::STRIDE_W'(1);
            rows_reg   <= rdc_pkg::ROWS_W'(1);
            dir_reg    <= rdc_pkg::DIR_ENCODE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                rdc_pkg::REG_LINE_STRIDE: stride_reg <= cfg_wdata[rdc_pkg::STRIDE_W-1:0];
                rdc_pkg::REG_ROW_COUNT:   rows_reg   <= cfg_wdata[rdc_pkg::ROWS_W-1:0];
                rdc_pkg::REG_DIRECTION:   dir_reg    <= rdc_pkg::dir_t'(cfg_wdata[0]);
                default:
                begin
                end
            endcase
        end
    end

    // zero stride acts as one, oversized stride saturates to the store depth
    always_comb
    begin
        if (stride_reg == '0)
        begin
            stride_eff = rdc_pkg::STRIDE_W'(1);
        end
        else if (stride_reg > rdc_pkg::STRIDE_W'(rdc_pkg::MAX_STRIDE))
        begin
            stride_eff = rdc_pkg::STRIDE_W'(rdc_pkg::MAX_STRIDE);
        end
        else
        begin
            stride_eff = stride_reg;
        end
    end

    // zero row count acts as one
    assign rows_eff = (rows_reg == '0) ? rdc_pkg::ROWS_W'(1) : rows_reg;

    assign col_plus = {1'b0, col_reg} + rdc_pkg::STRIDE_W'(1);
    assign row_plus = {1'b0, row_reg} + (rdc_pkg::ROWS_W + 1)'(1);
    assign row_end  = (col_plus >= stride_eff);
    assign last_row = (row_plus >= {1'b0, rows_eff});

    // handshakes
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || out_item.ready);
    assign in_item.ready = !s1_valid_reg || s1_adv;
    assign in_fire       = in_item.valid && in_item.ready;

    // line store, read on accept and written back as the item leaves the read stage
    rdc_ram #(
        .WIDTH (rdc_pkg::PIXEL_W),
        .DEPTH (rdc_pkg::MAX_STRIDE)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_reg.col),
        .wdata (raw),
        .re    (in_fire),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // filter: a byte written to the read column in the same cycle as the read is forwarded
    assign above = s1_reg.bypass ? byp_data_reg : ram_rdata;

    always_comb
    begin
        if (s1_reg.first)
        begin
            result = s1_reg.pixel;
            raw    = s1_reg.pixel;
        end
        else if (s1_reg.dir == rdc_pkg::DIR_ENCODE)
        begin
            result = s1_reg.pixel - above;
            raw    = s1_reg.pixel;
        end
        else
        begin
            result = s1_reg.pixel + above;
            raw    = result;
        end
    end

    // frame position and stage occupancy
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;

        if (in_fire)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_plus[rdc_pkg::ROWS_W-1:0];
            end
            else
            begin
                col_next = col_plus[rdc_pkg::COL_W-1:0];
            end
        end

        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_item.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg.pixel     <= in_item.pixel_in;
            s1_reg.col       <= col_reg;
            s1_reg.first     <= (row_reg == '0);
            s1_reg.frame_end <= row_end && last_row;
            s1_reg.dir       <= dir_reg;
            s1_reg.bypass    <= s1_adv && (s1_reg.col == col_reg);
            byp_data_reg     <= raw;
        end
        if (s1_adv)
        begin
            out_pixel_reg <= result;
            out_first_reg <= s1_reg.first;
            out_end_reg   <= s1_reg.frame_end;
        end
    end

    assign out_item.valid     = out_valid_reg;
    assign out_item.pixel_out = out_pixel_reg;
    assign out_item.first_row = out_first_reg;
    assign out_item.frame_end = out_end_reg;

endmodule
